// ===== hw/rtl/psda_pkg.sv =====
package psda_pkg;

  localparam int unsigned PixW = 16;
  localparam int unsigned CordSteps = 23;
  localparam int unsigned ZW = 26;

  typedef enum logic [1:0] {
    MODE_ANGLE = 2'd0,
    MODE_STOKES = 2'd1,
    MODE_POLAR = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  // arctangent table in 2^-16 degree
  function automatic logic [ZW-1:0] atan_deg(input logic [4:0] i);
    logic [ZW-1:0] v;
    case (i)
      5'd0: v = 26'd2949120;
      5'd1: v = 26'd1740967;
      5'd2: v = 26'd919879;
      5'd3: v = 26'd466945;
      5'd4: v = 26'd234379;
      5'd5: v = 26'd117304;
      5'd6: v = 26'd58666;
      5'd7: v = 26'd29335;
      5'd8: v = 26'd14668;
      5'd9: v = 26'd7334;
      5'd10: v = 26'd3667;
      5'd11: v = 26'd1833;
      5'd12: v = 26'd917;
      5'd13: v = 26'd458;
      5'd14: v = 26'd229;
      5'd15: v = 26'd115;
      5'd16: v = 26'd57;
      5'd17: v = 26'd29;
      5'd18: v = 26'd14;
      5'd19: v = 26'd7;
      5'd20: v = 26'd4;
      5'd21: v = 26'd2;
      5'd22: v = 26'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/psda_in_if.sv =====
interface psda_in_if;
  logic valid;
  logic ready;
  logic [15:0] pix_0deg;
  logic [15:0] pix_45deg;
  logic [15:0] pix_135deg;
  logic [15:0] pix_90deg;
  modport source (output valid, pix_0deg, pix_45deg, pix_135deg, pix_90deg, input ready);
  modport sink (input valid, pix_0deg, pix_45deg, pix_135deg, pix_90deg, output ready);
endinterface

// ===== hw/rtl/psda_out_if.sv =====
interface psda_out_if;
  logic valid;
  logic ready;
  logic [15:0] chan_a;
  logic [15:0] chan_b;
  logic [15:0] chan_c;
  logic [15:0] chan_d;
  modport source (output valid, chan_a, chan_b, chan_c, chan_d, input ready);
  modport sink (input valid, chan_a, chan_b, chan_c, chan_d, output ready);
endinterface

// ===== hw/rtl/psda_cordic_cell.sv =====
// one CORDIC vectoring step, registered, moves with the pipeline enable
module psda_cordic_cell
  import psda_pkg::*;
#(
  parameter int unsigned STEP = 0,
  parameter int unsigned XW = 44
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [XW-1:0] y_i,
  input  logic signed [ZW:0]   z_i,
  output logic signed [XW-1:0] x_o,
  output logic signed [XW-1:0] y_o,
  output logic signed [ZW:0]   z_o
);
  logic signed [XW-1:0] x_nxt, y_nxt;
  logic signed [ZW:0] z_nxt, ang;

  // rotate toward the x axis
  always_comb begin
    ang = signed'({1'b0, atan_deg(5'(STEP))});
    if (y_i > 0) begin
      x_nxt = x_i + (y_i >>> STEP);
      y_nxt = y_i - (x_i >>> STEP);
      z_nxt = z_i + ang;
    end else begin
      x_nxt = x_i - (y_i >>> STEP);
      y_nxt = y_i + (x_i >>> STEP);
      z_nxt = z_i - ang;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_o <= x_nxt;
      y_o <= y_nxt;
      z_o <= z_nxt;
    end
  end
endmodule

// ===== hw/rtl/psda_sqrt_cell.sv =====
// one restoring square root digit, registered
module psda_sqrt_cell #(
  parameter int unsigned BIT = 0,
  parameter int unsigned RW = 38,
  parameter int unsigned QW = 19
) (
  input  logic          clk,
  input  logic          en,
  input  logic [RW-1:0] rem_i,
  input  logic [QW-1:0] q_i,
  output logic [RW-1:0] rem_o,
  output logic [QW-1:0] q_o
);
  logic [RW+1:0] trial;
  logic [RW-1:0] rem_nxt;
  logic [QW-1:0] q_nxt;

  // try setting this bit of the root
  always_comb begin
    trial = ({2'b0, q_i} << (BIT + 1)) + ((RW+2)'(1) << (2 * BIT));
    if (trial <= {2'b0, rem_i}) begin
      rem_nxt = rem_i - trial[RW-1:0];
      q_nxt = q_i | (QW'(1) << BIT);
    end else begin
      rem_nxt = rem_i;
      q_nxt = q_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o <= rem_nxt;
      q_o <= q_nxt;
    end
  end
endmodule

// ===== hw/rtl/psda_div_cell.sv =====
// one restoring division bit, registered
module psda_div_cell #(
  parameter int unsigned NW = 64,
  parameter int unsigned DW = 18
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num_i,
  input  logic [DW:0]   rem_i,
  input  logic [DW-1:0] den_i,
  output logic [NW-1:0] num_o,
  output logic [DW:0]   rem_o,
  output logic [DW-1:0] den_o
);
  logic [DW+1:0] sh;
  logic [DW:0] rem_nxt;

  always_comb begin
    sh = {rem_i, num_i[NW-1]};
    if (sh >= {2'b0, den_i}) rem_nxt = (DW+1)'(sh - {2'b0, den_i});
    else rem_nxt = sh[DW:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_o <= {num_i[NW-2:0], (sh >= {2'b0, den_i})};
      rem_o <= rem_nxt;
      den_o <= den_i;
    end
  end
endmodule

// ===== hw/rtl/polarization_stokes_dop_aop.sv =====
// Polarization superpixel processor.
// in_ carries one 2x2 superpixel request (0, 45, 135, 90 degree intensities);
// out_ carries one request of four 16-bit channels per input.
// cfg_we/cfg_wdata write output_mode (0 passthrough, 1 Stokes, 2 DoP/AoP);
// write it only while the pipeline is empty.
// Every item flows through a fixed chain of register cells: 23 CORDIC cells
// for the angle, in parallel a root chain of QW cells (35 at 16 bits) and a
// divider chain of QW cells, then the output register; while the receiver
// does not stall, throughput is one item per cycle.
// The whole chain advances when the output register is free or taken;
// when the receiver stalls the chain freezes and in_ready drops, no request
// is lost. Reset clears the valid bits and sets output_mode to 1.
// DoP: t = floor(sqrt(16*F^2*mag2)/sum) exactly, by isqrt then floor divide
// of the integer root, with a final exactness test that decides ties.
module polarization_stokes_dop_aop
  import psda_pkg::*;
#(
  parameter int unsigned PIXEL_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  psda_in_if.sink    in_ch,
  psda_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic [1:0] cfg_wdata
);
  localparam int unsigned PB = PIXEL_BITS;
  localparam logic [PB:0] FULL = (PB+1)'((1 << PB) - 1);
  localparam int unsigned XW = PB + 28;
  // radicand 16*F^2*mag2 < 2^(4PB+6)
  localparam int unsigned RW = 4 * PB + 6;
  localparam int unsigned QW = 2 * PB + 3;
  localparam int unsigned SW = PB + 2;
  localparam int unsigned NC = QW;
  localparam int unsigned LAT = NC + QW + 2;

  logic [1:0] mode_r;
  logic advance;
  logic [LAT-1:0] vld_r;
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) mode_r <= 2'(MODE_STOKES);
    else if (cfg_we) mode_r <= cfg_wdata;
  end

  assign advance = !out_valid_r || out_ch.ready;
  assign in_ch.ready = advance;

  // stage 0: front end
  logic [PB-1:0] i0, i45, i135, i90;
  logic [PB+1:0] sum;
  logic signed [PB:0] s1, s2;
  logic [PB-1:0] ax, ay;
  logic [2*PB:0] mag2;
  assign i0 = in_ch.pix_0deg[PB-1:0];
  assign i45 = in_ch.pix_45deg[PB-1:0];
  assign i135 = in_ch.pix_135deg[PB-1:0];
  assign i90 = in_ch.pix_90deg[PB-1:0];
  assign sum = (PB+2)'(i0) + (PB+2)'(i45) + (PB+2)'(i135) + (PB+2)'(i90);
  assign s1 = signed'({1'b0, i0}) - signed'({1'b0, i90});
  assign s2 = signed'({1'b0, i45}) - signed'({1'b0, i135});
  assign ax = s1[PB] ? PB'(-s1) : PB'(s1);
  assign ay = s2[PB] ? PB'(-s2) : PB'(s2);
  assign mag2 = (2*PB+1)'(ax * ax) + (2*PB+1)'(ay * ay);

  typedef struct packed {
    logic [1:0] mode;
    logic [PB-1:0] p0, p45, p135, p90;
    logic [PB+1:0] sum;
    logic s1n, s2n;
    logic [1:0] special; // 0 cordic, 1 zero deg, 2 ninety, 3 forty-five
    logic both_zero;
    logic [PB:0] sb, sc;
  } side_t;

  side_t side0, side_r [LAT];
  always_comb begin
    side0.mode = mode_r;
    side0.p0 = i0; side0.p45 = i45; side0.p135 = i135; side0.p90 = i90;
    side0.sum = sum;
    side0.s1n = s1[PB];
    side0.s2n = s2[PB];
    side0.both_zero = (ax == '0) && (ay == '0);
    if (ay == '0) side0.special = 2'd1;
    else if (ax == '0) side0.special = 2'd2;
    else if (ax == ay) side0.special = 2'd3;
    else side0.special = 2'd0;
    side0.sb = (PB+1)'({1'b0, i0} + FULL - {1'b0, i90});
    side0.sc = (PB+1)'({1'b0, i45} + FULL - {1'b0, i135});
  end

  // side band delay line and valid bits
  always_ff @(posedge clk) begin
    if (advance) begin
      side_r[0] <= side0;
      for (int k = 1; k < LAT; k++) side_r[k] <= side_r[k-1];
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      vld_r <= {vld_r[LAT-2:0], in_ch.valid};
      out_valid_r <= vld_r[LAT-1];
    end
  end

  // angle chain
  logic signed [XW-1:0] cx [CordSteps+1];
  logic signed [XW-1:0] cy [CordSteps+1];
  logic signed [ZW:0] cz [CordSteps+1];
  always_ff @(posedge clk) begin
    if (advance) begin
      cx[0] <= signed'(XW'(ax) << 24);
      cy[0] <= signed'(XW'(ay) << 24);
      cz[0] <= '0;
    end
  end
  for (genvar g = 0; g < CordSteps; g++) begin : g_cord
    psda_cordic_cell #(.STEP(g), .XW(XW)) u_cell (
      .clk(clk), .en(advance),
      .x_i(cx[g]), .y_i(cy[g]), .z_i(cz[g]),
      .x_o(cx[g+1]), .y_o(cy[g+1]), .z_o(cz[g+1])
    );
  end
  // phi held until the end of the longer chain
  localparam int unsigned ZDLY = LAT - CordSteps - 1;
  logic [ZW-1:0] phi_r [ZDLY];
  logic [ZW-1:0] phi0;
  side_t sz;
  assign sz = side_r[CordSteps];
  always_comb begin
    if (sz.special == 2'd1) phi0 = '0;
    else if (sz.special == 2'd2) phi0 = ZW'(90 * 65536);
    else if (sz.special == 2'd3) phi0 = ZW'(45 * 65536);
    else if (cz[CordSteps] < 0) phi0 = '0;
    else if (cz[CordSteps] > (ZW+1)'(90 * 65536)) phi0 = ZW'(90 * 65536);
    else phi0 = ZW'(cz[CordSteps]);
  end
  always_ff @(posedge clk) begin
    if (advance) begin
      phi_r[0] <= phi0;
      for (int k = 1; k < ZDLY; k++) phi_r[k] <= phi_r[k-1];
    end
  end

  // magnitude chain: square root of 16*F^2*mag2
  logic [RW-1:0] radicand;
  logic [RW-1:0] sr [QW+1];
  logic [QW-1:0] sq [QW+1];
  logic [2*PB:0] mag2_r;
  always_ff @(posedge clk) begin
    if (advance) mag2_r <= mag2;
  end
  // F^2*mag2 split: registered product feeds the chain
  logic [RW-1:0] rad_r;
  assign radicand = RW'((RW)'(FULL) * RW'(FULL) * RW'(mag2_r)) << 4;
  always_ff @(posedge clk) begin
    if (advance) rad_r <= radicand;
  end
  assign sr[0] = rad_r;
  assign sq[0] = '0;
  for (genvar g = 0; g < QW; g++) begin : g_sqrt
    psda_sqrt_cell #(.BIT(QW-1-g), .RW(RW), .QW(QW)) u_cell (
      .clk(clk), .en(advance),
      .rem_i(sr[g]), .q_i(sq[g]), .rem_o(sr[g+1]), .q_o(sq[g+1])
    );
  end
  // root r, exact flag; divide r by sum (floor gives t since floor(sqrt)/sum)
  logic [QW-1:0] dn [NC+1];
  logic [SW:0] dr [NC+1];
  logic [SW-1:0] dd [NC+1];
  side_t sd;
  assign sd = side_r[QW+1];
  logic exact_r [NC+1];
  assign dn[0] = sq[QW];
  assign dr[0] = '0;
  assign dd[0] = sd.sum;
  assign exact_r[0] = (sr[QW] == '0);
  for (genvar g = 0; g < NC; g++) begin : g_div
    psda_div_cell #(.NW(QW), .DW(SW)) u_cell (
      .clk(clk), .en(advance),
      .num_i(dn[g]), .rem_i(dr[g]), .den_i(dd[g]),
      .num_o(dn[g+1]), .rem_o(dr[g+1]), .den_o(dd[g+1])
    );
    always_ff @(posedge clk) begin
      if (advance) exact_r[g+1] <= exact_r[g];
    end
  end

  // final stage: rounding and mode select
  side_t sf;
  logic [QW-1:0] t, q;
  logic tie;
  logic [ZW+8:0] aa;
  logic [16:0] ar;
  logic [ZW+8-17:0] aq;
  logic [15:0] a_nxt, b_nxt, c_nxt, d_nxt, aop;
  logic [PB-1:0] quarter;
  logic [PB+1:0] qs;
  assign sf = side_r[LAT-1];
  always_comb begin
    t = dn[NC];
    // t odd: tie only when root exact and division exact
    tie = exact_r[NC] && (dr[NC] == '0);
    q = t >> 1;
    if (t[0]) q = tie ? q + QW'(q[0]) : q + QW'(1);
    // angle placement
    if (!sf.s1n && !sf.s2n) aa = (ZW+9)'(phi_r[ZDLY-1]);
    else if (sf.s1n && !sf.s2n) aa = (ZW+9)'(180 * 65536) - (ZW+9)'(phi_r[ZDLY-1]);
    else if (sf.s1n) aa = (ZW+9)'(180 * 65536) + (ZW+9)'(phi_r[ZDLY-1]);
    else aa = (ZW+9)'(360 * 65536) - (ZW+9)'(phi_r[ZDLY-1]);
    ar = aa[16:0];
    aq = aa[ZW+8:17];
    if (ar > 17'h10000) aq = aq + 1'b1;
    else if (ar == 17'h10000) aq = aq + aq[0];
    aop = sf.both_zero ? 16'd0 : {8'd0, aq[7:0]};
    qs = sf.sum >> 2;
    if (sf.sum[1:0] == 2'd3 || (sf.sum[1:0] == 2'd2 && qs[0])) qs = qs + 1'b1;
    quarter = PB'(qs);
    a_nxt = '0; b_nxt = '0; c_nxt = '0; d_nxt = '0;
    unique case (mode_t'(sf.mode))
      MODE_ANGLE: begin
        a_nxt = 16'(sf.p0); b_nxt = 16'(sf.p45);
        c_nxt = 16'(sf.p135); d_nxt = 16'(sf.p90);
      end
      MODE_STOKES: begin
        a_nxt = 16'(quarter);
        b_nxt = 16'((sf.sb >> 1) + (sf.sb[0] & sf.sb[1]));
        c_nxt = 16'((sf.sc >> 1) + (sf.sc[0] & sf.sc[1]));
      end
      MODE_POLAR: begin
        if (sf.sum == '0) a_nxt = '0;
        else if (q > QW'(FULL)) a_nxt = 16'(FULL);
        else a_nxt = 16'(q);
        b_nxt = aop;
        c_nxt = 16'(quarter);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_ch.chan_a <= a_nxt;
      out_ch.chan_b <= b_nxt;
      out_ch.chan_c <= c_nxt;
      out_ch.chan_d <= d_nxt;
    end
  end
  assign out_ch.valid = out_valid_r;
endmodule

// ===== test/psda_checker.sv =====
module psda_checker
  import psda_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  psda_in_if         in_ch,
  psda_out_if        out_ch,
  input  logic       cfg_we,
  input  logic [1:0] cfg_wdata,
  output int         fail_count,
  output int         pending_count,
  output int         result_count
);

  localparam longint unsigned FullScale = 65535;
  localparam longint DegUnit = 65536;

  typedef struct packed {
    logic [15:0] chan_a;
    logic [15:0] chan_b;
    logic [15:0] chan_c;
    logic [15:0] chan_d;
  } chans_t;

  mode_t  cur_mode;
  chans_t chans_due[$];

  function automatic longint unsigned round_quarter(input longint unsigned v);
    longint unsigned q;
    q = v >> 2;
    if ((v & 3) > 2) q++;
    else if ((v & 3) == 2) q += q & 1;
    return q;
  endfunction

  function automatic longint unsigned round_half(input longint unsigned v);
    longint unsigned q;
    q = v >> 1;
    if (v & 1) q += q & 1;
    return q;
  endfunction

  // degree of polarization: largest t with (t*sum)^2 <= 16*F^2*mag2, then halved
  function automatic logic [15:0] degree_of_pol(input longint unsigned sum,
                                                input longint unsigned mag2);
    logic [127:0] rhs, prod;
    longint unsigned lo, hi, mid, q;
    if (sum == 0) return '0;
    rhs = 128'(16 * FullScale * FullScale) * 128'(mag2);
    lo = 0;
    hi = 2 * FullScale + 2;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      prod = 128'(mid * sum);
      if (prod * prod <= rhs) lo = mid;
      else hi = mid - 1;
    end
    q = lo >> 1;
    if (lo & 1) begin
      prod = 128'(lo * sum);
      // exact tie rounds to even
      if (prod * prod == rhs) q += q & 1;
      else q++;
    end
    if (q > FullScale) q = FullScale;
    return q[15:0];
  endfunction

  // angle of polarization via cordic vectoring on the first quadrant
  function automatic logic [15:0] angle_of_pol(input longint s1, input longint s2);
    longint ax, ay, x, y, z, xs, ys, phi, a;
    longint unsigned ua, q, r;
    ax = s1 < 0 ? -s1 : s1;
    ay = s2 < 0 ? -s2 : s2;
    if (ax == 0 && ay == 0) return '0;
    if (ay == 0) phi = 0;
    else if (ax == 0) phi = 90 * DegUnit;
    else if (ax == ay) phi = 45 * DegUnit;
    else begin
      x = ax <<< 24;
      y = ay <<< 24;
      z = 0;
      for (int i = 0; i < 23; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x += ys; y -= xs; z += longint'(atan_deg(5'(i)));
        end else begin
          x -= ys; y += xs; z -= longint'(atan_deg(5'(i)));
        end
      end
      if (z < 0) z = 0;
      if (z > 90 * DegUnit) z = 90 * DegUnit;
      phi = z;
    end
    if (s1 >= 0 && s2 >= 0) a = phi;
    else if (s1 < 0 && s2 >= 0) a = 180 * DegUnit - phi;
    else if (s1 < 0) a = 180 * DegUnit + phi;
    else a = 360 * DegUnit - phi;
    ua = longint'(a);
    q = ua >> 17;
    r = ua & 64'h1FFFF;
    if (r > 64'h10000) q++;
    else if (r == 64'h10000) q += q & 1;
    return 16'(q & 8'hFF);
  endfunction

  function automatic chans_t predict_chans(input mode_t m, input logic [15:0] i0,
                                           input logic [15:0] i45,
                                           input logic [15:0] i135,
                                           input logic [15:0] i90);
    chans_t c;
    longint unsigned sum, mag2;
    longint s1, s2;
    c = '0;
    sum = i0 + i45 + i135 + i90;
    s1 = longint'(i0) - longint'(i90);
    s2 = longint'(i45) - longint'(i135);
    case (m)
      MODE_ANGLE: begin
        c = {i0, i45, i135, i90};
      end
      MODE_STOKES: begin
        c.chan_a = 16'(round_quarter(sum));
        c.chan_b = 16'(round_half(i0 + FullScale - i90));
        c.chan_c = 16'(round_half(i45 + FullScale - i135));
      end
      MODE_POLAR: begin
        mag2 = longint'(s1 * s1) + longint'(s2 * s2);
        c.chan_a = degree_of_pol(sum, mag2);
        c.chan_b = angle_of_pol(s1, s2);
        c.chan_c = 16'(round_quarter(sum));
      end
      default: c = '0;
    endcase
    return c;
  endfunction

  // track mode, queue predictions, compare results
  always @(posedge clk) begin
    chans_t got, want;
    if (!rst_n) begin
      cur_mode <= MODE_STOKES;
      chans_due.delete();
      fail_count <= 0;
      result_count <= 0;
    end else begin
      if (cfg_we) cur_mode <= mode_t'(cfg_wdata);
      if (in_ch.valid && in_ch.ready)
        chans_due = {chans_due, predict_chans(cur_mode, in_ch.pix_0deg, in_ch.pix_45deg,
                                              in_ch.pix_135deg, in_ch.pix_90deg)};
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.chan_a, out_ch.chan_b, out_ch.chan_c, out_ch.chan_d};
        result_count <= result_count + 1;
        if (chans_due.size() == 0) begin
          $error("result with no request pending: %h", got);
          fail_count <= fail_count + 1;
        end else begin
          want = chans_due.pop_front();
          if (got != want) begin
            fail_count <= fail_count + 1;
            if (got.chan_a != want.chan_a)
              $error("chan_a expected %0d got %0d", want.chan_a, got.chan_a);
            if (got.chan_b != want.chan_b)
              $error("chan_b expected %0d got %0d", want.chan_b, got.chan_b);
            if (got.chan_c != want.chan_c)
              $error("chan_c expected %0d got %0d", want.chan_c, got.chan_c);
            if (got.chan_d != want.chan_d)
              $error("chan_d expected %0d got %0d", want.chan_d, got.chan_d);
          end
        end
      end
    end
  end

  assign pending_count = chans_due.size();

endmodule

// ===== test/tb_polarization_stokes_dop_aop.sv =====
module tb_polarization_stokes_dop_aop;
  import psda_pkg::*;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_wdata;
  int         fail_count, pending_count, result_count;
  int         send_idle_pct, recv_stall_pct;
  int         sent_count;

  psda_in_if  in_ch();
  psda_out_if out_ch();

  polarization_stokes_dop_aop uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  psda_checker chk (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .fail_count(fail_count),
    .pending_count(pending_count), .result_count(result_count)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // receiver backpressure
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // present one superpixel request and hold it until taken
  task automatic send_pixel(input logic [15:0] p0, input logic [15:0] p45,
                            input logic [15:0] p135, input logic [15:0] p90);
    bit taken;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.pix_0deg <= p0;
    in_ch.pix_45deg <= p45;
    in_ch.pix_135deg <= p135;
    in_ch.pix_90deg <= p90;
    do begin
      @(negedge clk);
      taken = in_ch.ready;
      @(posedge clk);
    end while (!taken);
    sent_count++;
  endtask

  // drain, then write the mode register while idle
  task automatic set_mode(input mode_t m);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] pick_level(input int kind);
    case (kind)
      0: return 16'($urandom_range(0, 15));
      1: return 16'($urandom_range(65520, 65535));
      2: return 16'd0;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_random();
    logic [15:0] p0, p45, p135, p90;
    int shape;
    shape = $urandom_range(0, 9);
    p0 = pick_level($urandom_range(0, 5));
    p45 = pick_level($urandom_range(0, 5));
    p135 = pick_level($urandom_range(0, 5));
    p90 = pick_level($urandom_range(0, 5));
    // equal differences, zero differences and near-axis cases
    case (shape)
      0: p90 = p0;
      1: p135 = p45;
      2: begin
        p0 = 16'($urandom_range(30000, 65535));
        p90 = p0 - 16'($urandom_range(0, 30000));
        p45 = p90;
        p135 = p0;
      end
      3: p90 = p0 + 16'($urandom_range(0, 3));
      default: ;
    endcase
    send_pixel(p0, p45, p135, p90);
  endtask

  task automatic send_directed();
    send_pixel(16'd0, 16'd0, 16'd0, 16'd0);
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pixel(16'hFFFF, 16'd0, 16'd0, 16'd0);
    send_pixel(16'd0, 16'hFFFF, 16'd0, 16'd0);
    send_pixel(16'd0, 16'd0, 16'hFFFF, 16'd0);
    send_pixel(16'd0, 16'd0, 16'd0, 16'hFFFF);
    send_pixel(16'd300, 16'd300, 16'd100, 16'd100);
    send_pixel(16'd100, 16'd300, 16'd100, 16'd300);
    send_pixel(16'd100, 16'd100, 16'd300, 16'd300);
    send_pixel(16'd300, 16'd100, 16'd300, 16'd100);
    send_pixel(16'd500, 16'd7, 16'd7, 16'd20);
    send_pixel(16'd20, 16'd7, 16'd7, 16'd500);
    send_pixel(16'd1, 16'd0, 16'd0, 16'd0);
    send_pixel(16'd0, 16'd0, 16'd1, 16'd1);
    send_pixel(16'd1000, 16'd999, 16'd0, 16'd0);
    send_pixel(16'd0, 16'd1, 16'd1000, 16'd0);
    send_pixel(16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA);
    send_pixel(16'd1, 16'd2, 16'd3, 16'd4);
  endtask

  initial begin
    mode_t mode_order[4];
    int chunk;
    mode_order = '{MODE_POLAR, MODE_STOKES, MODE_ANGLE, MODE_NONE};
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.pix_0deg = '0;
    in_ch.pix_45deg = '0;
    in_ch.pix_135deg = '0;
    in_ch.pix_90deg = '0;
    out_ch.ready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    sent_count = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners in the reset mode, then every mode
    send_directed();
    foreach (mode_order[k]) begin
      set_mode(mode_order[k]);
      send_directed();
    end

    // random traffic under three idling profiles
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 80 : 0;
      recv_stall_pct = (phase == 0) ? 80 : (phase == 1) ? 18 : 0;
      foreach (mode_order[k]) begin
        set_mode(mode_order[k]);
        chunk = (mode_order[k] == MODE_POLAR) ? 130 : 65;
        repeat (chunk) send_random();
      end
    end
    set_mode(MODE_STOKES);
    repeat (40) send_random();

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("covered %0d superpixels, %0d results, all four modes and three stall mixes",
             sent_count, result_count);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("tb: failure");
    $finish;
  end

endmodule
